/* hw/rtl/fll_divider_parameter_solver_top_macros.svh */
// ----------------------------------------------------------------------------
// FLL parameter solver assertion macros
// Shared concurrent assertion forms for the solver checkers.
// ----------------------------------------------------------------------------
`ifndef FLL_DIVIDER_PARAMETER_SOLVER_TOP_MACROS_SVH
`define FLL_DIVIDER_PARAMETER_SOLVER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FDS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fds check failed");

// Next-cycle implication, disabled while reset is high.
`define FDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fds check failed");

`endif

/* hw/rtl/fds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL parameter solver package
// Widths, selection tables, status codes and the divider pipeline word.
// ----------------------------------------------------------------------------
package fds_pkg;

  localparam int unsigned RefW     = 28;
  localparam int unsigned FsW      = 20;
  localparam int unsigned DivW     = 24;  // divisor and partial remainder
  localparam int unsigned QuotW    = 26;  // kept quotient bits
  localparam int unsigned BestW    = 27;  // oscillator frequency, below 100 MHz
  localparam int unsigned ProdW    = 26;  // sample rate times scale factor
  localparam int unsigned FvcoW    = ProdW + 9;
  localparam int unsigned FracW    = 16;
  localparam int unsigned IntW     = QuotW - FracW;
  localparam int unsigned NumPreDiv = 4;
  localparam int unsigned NumRatio = 7;
  localparam int unsigned NumScale = 10;

  localparam logic [RefW-1:0]  FREF_LIMIT = 28'd13500000;
  localparam logic [FvcoW-1:0] FVCO_LOW   = 35'd90000000;
  localparam logic [FvcoW-1:0] FVCO_HIGH  = 35'd100000000;

  // Ratio thresholds on the divided reference, first match wins.
  localparam logic [18:0] RATIO_THRESH [NumRatio] = '{
    19'd512000, 19'd256000, 19'd128000, 19'd64000, 19'd32000, 19'd8000, 19'd4000
  };

  // Scale factors sorted from largest down, with their register codes.
  localparam logic [5:0] SCALE_FACTOR [NumScale] = '{
    6'd32, 6'd24, 6'd16, 6'd12, 6'd8, 6'd6, 6'd4, 6'd3, 6'd2, 6'd1
  };
  localparam logic [3:0] SCALE_CODE [NumScale] = '{
    4'd6, 4'd12, 4'd5, 4'd11, 4'd4, 4'd10, 4'd3, 4'd7, 4'd2, 4'd0
  };

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_PREDIV = 2'd1,
    STATUS_NO_RATIO  = 2'd2,
    STATUS_NO_SCALER = 2'd3
  } status_t;

  typedef struct packed {
    status_t         status;
    logic [1:0]      ref_div_code;
    logic [6:0]      ratio_code;
    logic [3:0]      scaler_code;
    logic [DivW-1:0] divisor;
    logic [DivW-1:0] rem;
    logic [QuotW-1:0] low;   // dividend bits still to shift in
    logic [QuotW-1:0] quot;
  } div_word_t;

endpackage

/* hw/rtl/fds_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL parameter solver request channel
// Valid/ready channel carrying a reference clock and a sample rate.
// ----------------------------------------------------------------------------
interface fds_req_if;
  logic                       valid;
  logic                       ready;
  logic [fds_pkg::RefW-1:0]   ref_clock_hz;
  logic [fds_pkg::FsW-1:0]    sample_rate_hz;

  modport source(output valid, output ref_clock_hz, output sample_rate_hz, input ready);
  modport sink(input valid, input ref_clock_hz, input sample_rate_hz, output ready);
endinterface

/* hw/rtl/fds_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL parameter solver result channel
// Valid/ready channel carrying the solved loop settings.
// ----------------------------------------------------------------------------
interface fds_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [1:0]                 ref_div_code;
  logic [6:0]                 ratio_code;
  logic [3:0]                 scaler_code;
  logic [fds_pkg::IntW-1:0]   loop_integer;
  logic [fds_pkg::FracW-1:0]  loop_fraction;

  modport source(output valid, output status, output ref_div_code, output ratio_code,
                 output scaler_code, output loop_integer, output loop_fraction,
                 input ready);
  modport sink(input valid, input status, input ref_div_code, input ratio_code,
               input scaler_code, input loop_integer, input loop_fraction,
               output ready);
endinterface

/* hw/rtl/fll_divider_parameter_solver_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL divider parameter solver
// Turns a reference clock and a sample rate into frequency-locked-loop settings.
// ----------------------------------------------------------------------------
// The block takes one request word per clock while the result side keeps up
// and returns one result word per request, in order. Each request passes in
// turn through a front stage that picks the pre-divider, the loop
// ratio and the output scaler, a row of 26 divider cells that each resolve one
// bit of (fvco << 16) / (fref * ratio), and the output register. Every stage
// stalls only when the stage after it is full and stalled, so bubbles close up
// and a new request is taken while a finished result waits to be read. There
// is no configuration, no memory and no warm-up after reset.
module fll_divider_parameter_solver_top (
  input  logic       clk,
  input  logic       rst,
  fds_req_if.sink    request,
  fds_rsp_if.source  result
);

  localparam int unsigned NumCells = fds_pkg::QuotW;

  // Stage 0 is the front stage, stages 1..NumCells are divider cells.
  logic               stg_valid [NumCells+1];
  fds_pkg::div_word_t stg_word  [NumCells+1];
  logic               stg_take  [NumCells+1];

  logic               out_valid;
  fds_pkg::div_word_t out_word;

  // Front: table selections, seed the divider with the oscillator frequency.
  fds_front u_front (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (request.valid),
    .ref_clock_hz   (request.ref_clock_hz),
    .sample_rate_hz (request.sample_rate_hz),
    .up_ready       (request.ready),
    .dn_valid       (stg_valid[0]),
    .dn_word        (stg_word[0]),
    .dn_ready       (stg_take[0])
  );

  // Divider row: each cell shifts in one dividend bit and emits one quotient bit.
  for (genvar i = 1; i <= NumCells; i++) begin : g_cell
    fds_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stg_valid[i-1]),
      .up_word  (stg_word[i-1]),
      .up_ready (stg_take[i-1]),
      .dn_valid (stg_valid[i]),
      .dn_word  (stg_word[i]),
      .dn_ready (stg_take[i])
    );
  end

  // Output register: take the last cell's word when empty or being drained.
  assign stg_take[NumCells] = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stg_take[NumCells]) begin
      out_valid <= stg_valid[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take[NumCells] && stg_valid[NumCells]) begin
      out_word <= stg_word[NumCells];
    end
  end

  // Split the quotient; failed requests carry an all-zero quotient already.
  assign result.valid         = out_valid;
  assign result.status        = out_word.status;
  assign result.ref_div_code  = out_word.ref_div_code;
  assign result.ratio_code    = out_word.ratio_code;
  assign result.scaler_code   = out_word.scaler_code;
  assign result.loop_integer  = out_word.quot[fds_pkg::QuotW-1:fds_pkg::FracW];
  assign result.loop_fraction = out_word.quot[fds_pkg::FracW-1:0];

endmodule

/* hw/rtl/fds_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL parameter solver front stage
// Pick pre-divider, ratio and scaler; seed the divider word.
// ----------------------------------------------------------------------------
module fds_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  input  logic [fds_pkg::RefW-1:0] ref_clock_hz,
  input  logic [fds_pkg::FsW-1:0]  sample_rate_hz,
  output logic                     up_ready,
  output logic                     dn_valid,
  output fds_pkg::div_word_t       dn_word,
  input  logic                     dn_ready
);

  logic                       pd_found;
  logic [1:0]                 pd_code;
  logic [fds_pkg::RefW-1:0]   fref;
  logic [fds_pkg::DivW-1:0]   fref_n;
  logic                       r_found;
  logic [2:0]                 r_idx;
  logic                       s_found;
  logic [3:0]                 s_code;
  logic [fds_pkg::BestW-1:0]  best;
  logic [fds_pkg::ProdW-1:0]  prod;
  logic [fds_pkg::FvcoW-1:0]  fvco;
  fds_pkg::div_word_t         word_next;

  // Pre-divider: smallest shift that brings the reference to or under the limit.
  always_comb begin
    pd_found = 1'b0;
    pd_code  = '0;
    fref     = '0;
    for (int i = fds_pkg::NumPreDiv - 1; i >= 0; i--) begin
      if ((ref_clock_hz >> i) <= fds_pkg::FREF_LIMIT) begin
        pd_found = 1'b1;
        pd_code  = 2'(i);
        fref     = ref_clock_hz >> i;
      end
    end
  end

  assign fref_n = fref[fds_pkg::DivW-1:0];

  // Ratio: first threshold met, thresholds descend.
  always_comb begin
    r_found = 1'b0;
    r_idx   = '0;
    for (int i = fds_pkg::NumRatio - 1; i >= 0; i--) begin
      if (fref_n >= fds_pkg::DivW'(fds_pkg::RATIO_THRESH[i])) begin
        r_found = 1'b1;
        r_idx   = 3'(i);
      end
    end
  end

  // Scaler: largest factor whose frequency lands inside the window.
  always_comb begin
    s_found = 1'b0;
    s_code  = '0;
    best    = '0;
    prod    = '0;
    fvco    = '0;
    for (int i = fds_pkg::NumScale - 1; i >= 0; i--) begin
      prod = fds_pkg::ProdW'(sample_rate_hz) * fds_pkg::ProdW'(fds_pkg::SCALE_FACTOR[i]);
      fvco = {prod, 9'd0};
      if ((fvco > fds_pkg::FVCO_LOW) && (fvco < fds_pkg::FVCO_HIGH)) begin
        s_found = 1'b1;
        s_code  = fds_pkg::SCALE_CODE[i];
        best    = fvco[fds_pkg::BestW-1:0];
      end
    end
  end

  always_comb begin
    word_next              = '0;
    word_next.status       = fds_pkg::STATUS_OK;
    word_next.divisor      = fds_pkg::DivW'(1);
    priority if (!pd_found) begin
      word_next.status = fds_pkg::STATUS_NO_PREDIV;
    end else if (!r_found) begin
      word_next.status = fds_pkg::STATUS_NO_RATIO;
    end else if (!s_found) begin
      word_next.status = fds_pkg::STATUS_NO_SCALER;
    end else begin
      word_next.ref_div_code = pd_code;
      word_next.ratio_code   = 7'd1 << r_idx;
      word_next.scaler_code  = s_code;
      word_next.divisor      = fref_n << r_idx;
      word_next.rem          = fds_pkg::DivW'(best[fds_pkg::BestW-1:10]);
      word_next.low          = {best[9:0], 16'd0};
    end
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word <= word_next;
    end
  end

endmodule

/* hw/rtl/fds_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL parameter solver divider cell
// One restoring division step: one quotient bit, then hand on.
// ----------------------------------------------------------------------------
module fds_div_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  input  fds_pkg::div_word_t up_word,
  output logic               up_ready,
  output logic               dn_valid,
  output fds_pkg::div_word_t dn_word,
  input  logic               dn_ready
);

  logic [fds_pkg::DivW:0] trial;
  logic [fds_pkg::DivW:0] diff;
  logic                   ge;
  fds_pkg::div_word_t     word_next;

  assign trial = {up_word.rem, up_word.low[fds_pkg::QuotW-1]};
  assign diff  = trial - {1'b0, up_word.divisor};
  assign ge    = trial >= {1'b0, up_word.divisor};

  always_comb begin
    word_next      = up_word;
    word_next.rem  = ge ? diff[fds_pkg::DivW-1:0] : trial[fds_pkg::DivW-1:0];
    word_next.low  = {up_word.low[fds_pkg::QuotW-2:0], 1'b0};
    word_next.quot = {up_word.quot[fds_pkg::QuotW-2:0], ge};
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_word <= word_next;
    end
  end

endmodule

/* hw/rtl/fds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FLL parameter solver checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "fll_divider_parameter_solver_top_macros.svh"

module fds_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [1:0]                 status,
  input logic [1:0]                 ref_div_code,
  input logic [6:0]                 ratio_code,
  input logic [3:0]                 scaler_code,
  input logic [fds_pkg::IntW-1:0]   loop_integer,
  input logic [fds_pkg::FracW-1:0]  loop_fraction
);

  logic        ok;
  logic [40:0] payload;
  logic        settings_zero;
  logic        code_ok;

  assign ok      = (status == fds_pkg::STATUS_OK);
  assign payload = {status, ref_div_code, ratio_code, scaler_code, loop_integer,
                    loop_fraction};

  assign settings_zero = (ref_div_code == 2'd0) && (ratio_code == 7'd0) &&
                         (scaler_code == 4'd0) && (loop_integer == '0) &&
                         (loop_fraction == '0);

  always_comb begin
    code_ok = 1'b0;
    for (int i = 0; i < fds_pkg::NumScale; i++) begin
      if (scaler_code == fds_pkg::SCALE_CODE[i]) code_ok = 1'b1;
    end
  end

  // Hold a stalled result word.
  `FDS_ASSERT_NEXT(a_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(payload))

  // Drop every setting on a failed solve.
  `FDS_ASSERT_IMP(a_fail_zero, clk, rst, res_valid && !ok, settings_zero)

  // A good solve carries exactly one ratio bit.
  `FDS_ASSERT_IMP(a_ratio_onehot, clk, rst, res_valid && ok, $onehot(ratio_code))

  // A good solve carries a scaler code from the table.
  `FDS_ASSERT_IMP(a_scaler_code, clk, rst, res_valid && ok, code_ok)

endmodule

bind fll_divider_parameter_solver_top fds_checker u_fds_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .status        (result.status),
  .ref_div_code  (result.ref_div_code),
  .ratio_code    (result.ratio_code),
  .scaler_code   (result.scaler_code),
  .loop_integer  (result.loop_integer),
  .loop_fraction (result.loop_fraction)
);
